// ===== sv/chacha_pkg.sv =====
// Shared types, constants and helpers for the ChaCha20 stream cipher.
// No dependencies; every other file refers to it by scoped names.
package chacha_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ROWS     = 4;
  localparam int unsigned COLS     = 4;
  localparam int unsigned BLK_WDS  = 8;   // 64-bit keystream words per block
  localparam int unsigned ROUNDS   = 20;
  localparam int unsigned ROUND_W  = 5;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned TDATA_W  = 72;
  localparam int unsigned CFG_IX_W = 3;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROWS-1:0][WORD_W-1:0] quad_t;
  typedef logic [BLK_WDS-1:0][DATA_W-1:0] block_t;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_KEY0    = 3'd0,
    CFG_KEY1    = 3'd1,
    CFG_KEY2    = 3'd2,
    CFG_KEY3    = 3'd3,
    CFG_NONCE   = 3'd4,
    CFG_START   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_FEED
  } eng_state_t;

  typedef struct packed {
    logic [3:0][DATA_W-1:0] key;
    logic [DATA_W-1:0]      nonce;
    word_t                  counter;
  } blk_cfg_t;

  typedef struct packed {
    logic take;   // current prefetched block moves into the consumer
    logic abort;  // drop prefetched or in-flight block
  } gen_ctrl_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage

// ===== sv/chacha20_stream_cipher_top.sv =====
// ChaCha20 stream cipher top level: configuration registers, keystream
// consumer and output register. Uses chacha_pkg and chacha_block_gen.
//
// Each input transaction carries up to eight message bytes that are XORed
// with the next eight keystream bytes; bytes beyond the count come out zero.
// The generator builds a keystream block in a load step, twenty rounds on a
// row of four quarter-round cells and a feed-forward step, and prefetches it
// while the eight items of the previous block are consumed. The prefetch
// starts the cycle after a block is taken, and items within a block follow
// back to back while the output is not stalled. The first item of a message
// waits for its block; a tlast transaction or a register write drops the
// prefetched block and the generator restarts.
module chacha20_stream_cipher_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [chacha_pkg::TDATA_W-1:0]    in_tdata,  // data_in[63:0], byte_count[67:64], pad
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [chacha_pkg::TDATA_W-1:0]    out_tdata, // data_out[63:0], count_out[67:64], pad
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [chacha_pkg::CFG_IX_W-1:0]   cfg_index,
  input  logic [chacha_pkg::DATA_W-1:0]     cfg_data
);

  logic [3:0][chacha_pkg::DATA_W-1:0] key_r;
  logic [chacha_pkg::DATA_W-1:0] nonce_r;
  chacha_pkg::word_t start_r, blk_ctr_r, blk_ctr_nxt;
  logic open_r, open_nxt;
  logic [chacha_pkg::POS_W-1:0] pos_r, pos_nxt;
  chacha_pkg::block_t store_r;
  logic out_valid_r, out_valid_nxt;
  logic [chacha_pkg::DATA_W-1:0] out_data_r;
  logic [chacha_pkg::CNT_W-1:0] out_count_r;
  logic out_last_r;

  logic need_blk, accept, cfg_wr, blk_valid;
  chacha_pkg::block_t blk;
  chacha_pkg::blk_cfg_t gen_cfg;
  chacha_pkg::gen_ctrl_t gen_ctrl;
  logic [chacha_pkg::DATA_W-1:0] ks_word, mask, in_data;
  logic [chacha_pkg::CNT_W-1:0] in_count;

  assign in_data  = in_tdata[chacha_pkg::DATA_W-1:0];
  assign in_count = in_tdata[chacha_pkg::DATA_W +: chacha_pkg::CNT_W];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  assign need_blk  = !open_r || (pos_r == '0);
  assign in_tready = (!out_valid_r || out_tready) && (!need_blk || blk_valid);
  assign accept    = in_tvalid && in_tready;

  assign gen_cfg.key     = key_r;
  assign gen_cfg.nonce   = nonce_r;
  assign gen_cfg.counter = open_r ? blk_ctr_r : start_r;
  assign gen_ctrl.take   = accept && need_blk;
  assign gen_ctrl.abort  = cfg_wr || (accept && in_tlast);

  chacha_block_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (gen_cfg),
    .ctrl      (gen_ctrl),
    .blk_valid (blk_valid),
    .blk       (blk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
      start_r <= '0;
    end else if (cfg_wr) begin
      case (chacha_pkg::cfg_idx_t'(cfg_index))
        chacha_pkg::CFG_KEY0:  key_r[0] <= cfg_data;
        chacha_pkg::CFG_KEY1:  key_r[1] <= cfg_data;
        chacha_pkg::CFG_KEY2:  key_r[2] <= cfg_data;
        chacha_pkg::CFG_KEY3:  key_r[3] <= cfg_data;
        chacha_pkg::CFG_NONCE: nonce_r  <= cfg_data;
        chacha_pkg::CFG_START: start_r  <= cfg_data[chacha_pkg::WORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign ks_word = need_blk ? blk[0] : store_r[pos_r];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (chacha_pkg::CNT_W'(i) < in_count) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    blk_ctr_nxt   = blk_ctr_r;
    open_nxt      = open_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      open_nxt      = !in_tlast;
      pos_nxt       = need_blk ? chacha_pkg::POS_W'(1) : pos_r + 1'b1;
      if (need_blk) begin
        blk_ctr_nxt = gen_cfg.counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_ctr_r   <= '0;
      open_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      blk_ctr_r   <= blk_ctr_nxt;
      open_r      <= open_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the block being consumed; word 0 is taken straight from the prefetch
  always_ff @(posedge clk) begin
    if (gen_ctrl.take) begin
      store_r <= blk;
    end
    if (accept) begin
      out_data_r  <= (in_data ^ ks_word) & mask;
      out_count_r <= in_count;
      out_last_r  <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(chacha_pkg::TDATA_W - chacha_pkg::DATA_W - chacha_pkg::CNT_W){1'b0}},
                       out_count_r, out_data_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/chacha_qr_cell.sv =====
// Column cell: holds four state words; one quarter round per cycle on step.
// Uses chacha_pkg.
module chacha_qr_cell (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  chacha_pkg::quad_t init_q,
  input  chacha_pkg::quad_t route_q,
  output chacha_pkg::quad_t x_q,
  output chacha_pkg::quad_t qr_q
);

  chacha_pkg::quad_t x_r, x_nxt;
  chacha_pkg::word_t a1, a2, b1, b2, c1, c2, d1, d2;

  always_comb begin
    a1 = x_r[0] + x_r[1];
    d1 = chacha_pkg::rotl(x_r[3] ^ a1, 16);
    c1 = x_r[2] + d1;
    b1 = chacha_pkg::rotl(x_r[1] ^ c1, 12);
    a2 = a1 + b1;
    d2 = chacha_pkg::rotl(d1 ^ a2, 8);
    c2 = c1 + d2;
    b2 = chacha_pkg::rotl(b1 ^ c2, 7);
    qr_q = {d2, c2, b2, a2};
  end

  always_comb begin
    x_nxt = x_r;
    if (load) begin
      x_nxt = init_q;
    end else if (step) begin
      x_nxt = route_q;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  assign x_q = x_r;

endmodule

// ===== sv/chacha_block_gen.sv =====
// Keystream block generator: four quarter-round cells that trade rows between
// column and diagonal rounds, a round sequencer and the feed-forward buffer.
// Uses chacha_pkg and chacha_qr_cell.
module chacha_block_gen (
  input  logic                 clk,
  input  logic                 rst_n,
  input  chacha_pkg::blk_cfg_t cfg,
  input  chacha_pkg::gen_ctrl_t ctrl,
  output logic                 blk_valid,
  output chacha_pkg::block_t   blk
);

  chacha_pkg::eng_state_t state_r, state_nxt;
  logic [chacha_pkg::ROUND_W-1:0] round_r, round_nxt;
  logic load, step, feed;
  logic blk_valid_r, blk_valid_nxt;
  chacha_pkg::block_t blk_r;
  chacha_pkg::word_t [15:0] init_w;
  chacha_pkg::quad_t [chacha_pkg::COLS-1:0] init_q, route_q, x_q, qr_q;

  always_comb begin
    init_w[0]  = chacha_pkg::SIGMA0;
    init_w[1]  = chacha_pkg::SIGMA1;
    init_w[2]  = chacha_pkg::SIGMA2;
    init_w[3]  = chacha_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2*i] = cfg.key[i][31:0];
      init_w[5 + 2*i] = cfg.key[i][63:32];
    end
    init_w[12] = cfg.counter;
    init_w[13] = '0;
    init_w[14] = cfg.nonce[31:0];
    init_w[15] = cfg.nonce[63:32];
  end

  for (genvar c = 0; c < chacha_pkg::COLS; c++) begin : g_cell
    for (genvar r = 0; r < chacha_pkg::ROWS; r++) begin : g_row
      localparam int unsigned DIAG = (c + r) % chacha_pkg::COLS;
      localparam int unsigned UNDG = (c + chacha_pkg::COLS - r) % chacha_pkg::COLS;
      assign init_q[c][r] = init_w[chacha_pkg::COLS*r + c];
      // even rounds skew rows into diagonals, odd rounds skew them back
      assign route_q[c][r] = round_r[0] ? qr_q[UNDG][r] : qr_q[DIAG][r];
    end
    chacha_qr_cell u_cell (
      .clk     (clk),
      .load    (load),
      .step    (step),
      .init_q  (init_q[c]),
      .route_q (route_q[c]),
      .x_q     (x_q[c]),
      .qr_q    (qr_q[c])
    );
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    load = 1'b0;
    step = 1'b0;
    feed = 1'b0;
    case (state_r)
      chacha_pkg::ENG_IDLE: begin
        if (!blk_valid_r) begin
          load = 1'b1;
          round_nxt = '0;
          state_nxt = chacha_pkg::ENG_ROUND;
        end
      end
      chacha_pkg::ENG_ROUND: begin
        step = 1'b1;
        if (round_r == chacha_pkg::ROUND_W'(chacha_pkg::ROUNDS - 1)) begin
          state_nxt = chacha_pkg::ENG_FEED;
        end else begin
          round_nxt = round_r + 1'b1;
        end
      end
      chacha_pkg::ENG_FEED: begin
        feed = 1'b1;
        state_nxt = chacha_pkg::ENG_IDLE;
      end
      default: begin
        state_nxt = chacha_pkg::ENG_IDLE;
      end
    endcase
    if (ctrl.abort) begin
      load = 1'b0;
      feed = 1'b0;
      state_nxt = chacha_pkg::ENG_IDLE;
    end
  end

  always_comb begin
    blk_valid_nxt = blk_valid_r;
    if (ctrl.abort) begin
      blk_valid_nxt = 1'b0;
    end else if (feed) begin
      blk_valid_nxt = 1'b1;
    end else if (ctrl.take) begin
      blk_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chacha_pkg::ENG_IDLE;
      round_r     <= '0;
      blk_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      blk_valid_r <= blk_valid_nxt;
    end
  end

  // feed-forward: add the initial state and pack word pairs
  always_ff @(posedge clk) begin
    if (feed) begin
      for (int i = 0; i < chacha_pkg::BLK_WDS; i++) begin
        blk_r[i] <= {x_q[(2*i+1) % 4][(2*i+1) / 4] + init_w[2*i+1],
                     x_q[(2*i) % 4][(2*i) / 4] + init_w[2*i]};
      end
    end
  end

  assign blk_valid = blk_valid_r;
  assign blk       = blk_r;

endmodule

// ===== sv/chacha_checker.sv =====
// Port-level checks for the ChaCha20 stream cipher top level, bound to it.
// Uses chacha_pkg for widths.
module chacha_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [chacha_pkg::TDATA_W-1:0] in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [chacha_pkg::TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_count_copy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid && out_tdata[67:64] == $past(in_tdata[67:64]))
    else $error("result count does not follow accepted item");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[67:64] == 4'd1 |-> out_tdata[63:8] == '0)
    else $error("bytes beyond count not zero");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:68] == '0)
    else $error("tdata padding not zero");

endmodule

bind chacha20_stream_cipher_top chacha_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
